// ===== design/dmwb_pkg.sv =====
`default_nettype none

package dmwb_pkg;

    // line geometry, fixed by the field widths
    localparam int WORDS_PER_LINE = 4;
    localparam int WORD_BITS      = 8;
    localparam int LINE_BITS      = WORDS_PER_LINE * WORD_BITS;
    localparam int SEL_W          = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;

    // statistics counter width
    localparam int COUNT_W = 32;

    // default geometry of the two memories
    localparam int CACHE_LINES_DEFAULT = 16;
    localparam int STORE_LINES_DEFAULT = 256;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // outcome of one access, handed to the statistics block
    typedef struct packed {
        logic hit;
        logic is_write;
    } access_info_t;

endpackage

`default_nettype wire

// ===== design/dmwb_ram.sv =====
`default_nettype none

module dmwb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/dmwb_update.sv =====
`default_nettype none

module dmwb_update #(
    parameter int TAG_W = 4
) (
    input  wire logic                             req_kind,
    input  wire logic [TAG_W-1:0]                 req_tag,
    input  wire logic [dmwb_pkg::SEL_W-1:0]       req_sel,
    input  wire logic [dmwb_pkg::WORD_BITS-1:0]   req_data,
    input  wire logic                             old_valid,
    input  wire logic                             old_dirty,
    input  wire logic [TAG_W-1:0]                 old_tag,
    input  wire logic [dmwb_pkg::LINE_BITS-1:0]   old_line,
    input  wire logic [dmwb_pkg::LINE_BITS-1:0]   fill_line,
    output dmwb_pkg::access_info_t                info,
    output logic                                  write_back,
    output logic                                  new_dirty,
    output logic [dmwb_pkg::LINE_BITS-1:0]        new_line
);

    logic                             hit_c;
    logic                             is_write;
    logic [dmwb_pkg::LINE_BITS-1:0]   base_line;

    // hit test and victim check
    assign hit_c      = old_valid && (old_tag == req_tag);
    assign is_write   = (req_kind == dmwb_pkg::KIND_WRITE);
    assign write_back = !hit_c && old_valid && old_dirty;
    assign new_dirty  = hit_c ? (old_dirty || is_write) : is_write;
    assign base_line  = hit_c ? old_line : fill_line;

    // byte merge, word 0 sits in the high bits
    always_comb
    begin
        new_line = base_line;
        if (is_write)
        begin
            for (int w = 0; w < dmwb_pkg::WORDS_PER_LINE; w++)
            begin
                if (req_sel == dmwb_pkg::SEL_W'(w))
                begin
                    new_line[dmwb_pkg::LINE_BITS-1-w*dmwb_pkg::WORD_BITS -: dmwb_pkg::WORD_BITS]
                        = req_data;
                end
            end
        end
    end

    assign info.hit      = hit_c;
    assign info.is_write = is_write;

endmodule

`default_nettype wire

// ===== design/dmwb_stats.sv =====
`default_nettype none

module dmwb_stats (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire dmwb_pkg::access_info_t        info,
    output logic [dmwb_pkg::COUNT_W-1:0]       access_total,
    output logic [dmwb_pkg::COUNT_W-1:0]       hit_total,
    output logic [dmwb_pkg::COUNT_W-1:0]       miss_total,
    output logic [dmwb_pkg::COUNT_W-1:0]       read_miss_total,
    output logic [dmwb_pkg::COUNT_W-1:0]       write_miss_total
);

    logic [dmwb_pkg::COUNT_W-1:0] access_reg,     access_next;
    logic [dmwb_pkg::COUNT_W-1:0] hit_reg,        hit_next;
    logic [dmwb_pkg::COUNT_W-1:0] miss_reg,       miss_next;
    logic [dmwb_pkg::COUNT_W-1:0] read_miss_reg,  read_miss_next;
    logic [dmwb_pkg::COUNT_W-1:0] write_miss_reg, write_miss_next;

    function automatic logic [dmwb_pkg::COUNT_W-1:0] sat_inc(
        input logic [dmwb_pkg::COUNT_W-1:0] v
    );
        return (v == '1) ? v : v + dmwb_pkg::COUNT_W'(1);
    endfunction

    // saturating counters, bumped once per completed access
    always_comb
    begin
        access_next     = access_reg;
        hit_next        = hit_reg;
        miss_next       = miss_reg;
        read_miss_next  = read_miss_reg;
        write_miss_next = write_miss_reg;
        if (en)
        begin
            access_next = sat_inc(access_reg);
            if (info.hit)
            begin
                hit_next = sat_inc(hit_reg);
            end
            else
            begin
                miss_next = sat_inc(miss_reg);
                if (info.is_write)
                begin
                    write_miss_next = sat_inc(write_miss_reg);
                end
                else
                begin
                    read_miss_next = sat_inc(read_miss_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_reg     <= '0;
            hit_reg        <= '0;
            miss_reg       <= '0;
            read_miss_reg  <= '0;
            write_miss_reg <= '0;
        end
        else
        begin
            access_reg     <= access_next;
            hit_reg        <= hit_next;
            miss_reg       <= miss_next;
            read_miss_reg  <= read_miss_next;
            write_miss_reg <= write_miss_next;
        end
    end

    assign access_total     = access_reg;
    assign hit_total        = hit_reg;
    assign miss_total       = miss_reg;
    assign read_miss_total  = read_miss_reg;
    assign write_miss_total = write_miss_reg;

endmodule

`default_nettype wire

// ===== design/direct_mapped_write_back_cache.sv =====
// Direct-mapped write-back, write-allocate cache in front of a backing store.
// Input channel (in_valid/in_ready): one access per transfer, a line read
// (kind read) or a single byte write (kind write, word_select, write_data).
// Output channel (out_valid/out_ready): one result per access, with the hit
// flag, the write-back flag, the line after the access and the statistics.
// Flow: on the input transfer both memories read the tag/line entry and
// the store line into their registered read ports; the lookup state then
// writes back the victim and the updated entry and loads the result
// register. The result is offered once that register is loaded; no new
// access is taken until the lookup state has finished the read-modify-write
// of the cache entry memory, so one access is in flight at a time.
// Stall: while a result waits for out_ready the block still takes one new
// access and reads its entry, then holds before the update until the waiting
// result is taken.
// Reset: a clearing pass writes zero into every store line and invalidates
// every cache entry, one address a cycle, over all STORE_LINES addresses;
// in_ready stays low until it is done. Counters reset to zero.
`default_nettype none

module direct_mapped_write_back_cache #(
    parameter int CACHE_LINES = dmwb_pkg::CACHE_LINES_DEFAULT,
    parameter int STORE_LINES = dmwb_pkg::STORE_LINES_DEFAULT,
    localparam int ADDR_W     = $clog2(STORE_LINES)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             kind,
    input  wire logic [ADDR_W-1:0]                line_address,
    input  wire logic [dmwb_pkg::SEL_W-1:0]       word_select,
    input  wire logic [dmwb_pkg::WORD_BITS-1:0]   write_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  hit,
    output logic                                  wrote_back,
    output logic [dmwb_pkg::LINE_BITS-1:0]        line_data,
    output logic [dmwb_pkg::COUNT_W-1:0]          access_total,
    output logic [dmwb_pkg::COUNT_W-1:0]          hit_total,
    output logic [dmwb_pkg::COUNT_W-1:0]          miss_total,
    output logic [dmwb_pkg::COUNT_W-1:0]          read_miss_total,
    output logic [dmwb_pkg::COUNT_W-1:0]          write_miss_total
);

    localparam int IDX_W   = $clog2(CACHE_LINES);
    localparam int TAG_W   = (ADDR_W > IDX_W) ? ADDR_W - IDX_W : 1;
    localparam int LINE_W  = dmwb_pkg::LINE_BITS;
    localparam int ENTRY_W = 2 + TAG_W + LINE_W;

    dmwb_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    // request and result payload
    logic                               req_kind_reg;
    logic [ADDR_W-1:0]                  req_addr_reg;
    logic [dmwb_pkg::SEL_W-1:0]         req_sel_reg;
    logic [dmwb_pkg::WORD_BITS-1:0]     req_data_reg;
    logic                               hit_reg;
    logic                               wrote_back_reg;
    logic [LINE_W-1:0]                  line_reg;

    logic              accept;
    logic              clearing;
    logic              do_update;
    logic              proceed;
    logic [IDX_W-1:0]  req_idx;
    logic [TAG_W-1:0]  req_tag;
    logic [ADDR_W-1:0] victim_addr;

    logic [ENTRY_W-1:0] entry_rdata;
    logic [ENTRY_W-1:0] entry_wdata;
    logic [IDX_W-1:0]   entry_waddr;
    logic               entry_we;
    logic [LINE_W-1:0]  store_rdata;
    logic [LINE_W-1:0]  store_wdata;
    logic [ADDR_W-1:0]  store_waddr;
    logic               store_we;

    logic               old_valid;
    logic               old_dirty;
    logic [TAG_W-1:0]   old_tag;
    logic [LINE_W-1:0]  old_line;

    dmwb_pkg::access_info_t info;
    logic                   write_back_c;
    logic                   new_dirty;
    logic [LINE_W-1:0]      new_line;

    // tag and victim address; with no tag bits the pseudo-tag is always zero
    assign req_idx = req_addr_reg[IDX_W-1:0];
    generate
        if (ADDR_W > IDX_W)
        begin : g_tag
            assign req_tag     = req_addr_reg[ADDR_W-1:IDX_W];
            assign victim_addr = {old_tag, req_idx};
        end
        else
        begin : g_no_tag
            assign req_tag     = '0;
            assign victim_addr = ADDR_W'(req_idx);
        end
    endgenerate

    // cache entry fields: valid, dirty, tag, line
    assign old_valid = entry_rdata[ENTRY_W-1];
    assign old_dirty = entry_rdata[ENTRY_W-2];
    assign old_tag   = entry_rdata[LINE_W +: TAG_W];
    assign old_line  = entry_rdata[LINE_W-1:0];

    // sequencer
    assign proceed = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        in_ready   = 1'b0;
        clearing   = 1'b0;
        do_update  = 1'b0;
        case (state_reg)
            dmwb_pkg::ST_CLEAR:
            begin
                clearing = 1'b1;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(STORE_LINES - 1))
                begin
                    state_next = dmwb_pkg::ST_IDLE;
                end
            end
            dmwb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = dmwb_pkg::ST_LOOKUP;
                end
            end
            dmwb_pkg::ST_LOOKUP:
            begin
                if (proceed)
                begin
                    do_update  = 1'b1;
                    state_next = dmwb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmwb_pkg::ST_CLEAR;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_update)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmwb_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the request and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_kind_reg <= kind;
            req_addr_reg <= line_address;
            req_sel_reg  <= word_select;
            req_data_reg <= write_data;
        end
        if (do_update)
        begin
            hit_reg        <= info.hit;
            wrote_back_reg <= write_back_c;
            line_reg       <= new_line;
        end
    end

    // entry update logic
    dmwb_update #(
        .TAG_W (TAG_W)
    ) u_update (
        .req_kind   (req_kind_reg),
        .req_tag    (req_tag),
        .req_sel    (req_sel_reg),
        .req_data   (req_data_reg),
        .old_valid  (old_valid),
        .old_dirty  (old_dirty),
        .old_tag    (old_tag),
        .old_line   (old_line),
        .fill_line  (store_rdata),
        .info       (info),
        .write_back (write_back_c),
        .new_dirty  (new_dirty),
        .new_line   (new_line)
    );

    // cache entry memory: cleared on the sweep, rewritten on every access
    assign entry_we    = clearing || do_update;
    assign entry_waddr = clearing ? clr_reg[IDX_W-1:0] : req_idx;
    assign entry_wdata = clearing ? '0 : {1'b1, new_dirty, req_tag, new_line};

    dmwb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_LINES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (entry_waddr),
        .wdata (entry_wdata),
        .re    (accept),
        .raddr (line_address[IDX_W-1:0]),
        .rdata (entry_rdata)
    );

    // backing store: cleared on the sweep, takes dirty victims
    assign store_we    = clearing || (do_update && write_back_c);
    assign store_waddr = clearing ? clr_reg : victim_addr;
    assign store_wdata = clearing ? '0 : old_line;

    dmwb_ram #(
        .WIDTH (LINE_W),
        .DEPTH (STORE_LINES)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (accept),
        .raddr (line_address),
        .rdata (store_rdata)
    );

    // statistics, updated with the result register
    dmwb_stats u_stats (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (do_update),
        .info             (info),
        .access_total     (access_total),
        .hit_total        (hit_total),
        .miss_total       (miss_total),
        .read_miss_total  (read_miss_total),
        .write_miss_total (write_miss_total)
    );

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign wrote_back = wrote_back_reg;
    assign line_data  = line_reg;

endmodule

`default_nettype wire

// ===== design/dmwb_checker.sv =====
`default_nettype none

module dmwb_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          hit,
    input wire logic                          wrote_back,
    input wire logic [dmwb_pkg::LINE_BITS-1:0] line_data,
    input wire logic [dmwb_pkg::COUNT_W-1:0]   access_total,
    input wire logic [dmwb_pkg::COUNT_W-1:0]   hit_total,
    input wire logic [dmwb_pkg::COUNT_W-1:0]   miss_total,
    input wire logic [dmwb_pkg::COUNT_W-1:0]   read_miss_total,
    input wire logic [dmwb_pkg::COUNT_W-1:0]   write_miss_total
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_data) && $stable(access_total))
        else $error("result changed while stalled");

    // one access in flight: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on back-to-back cycles");

    // a hit never writes back a victim
    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !wrote_back)
        else $error("write-back reported on a hit");

    // accesses split into hits and misses until saturation
    a_access_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (access_total != '1) |-> access_total == hit_total + miss_total)
        else $error("access count differs from hits plus misses");

    // misses split into read and write misses until saturation
    a_miss_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (miss_total != '1) |->
            miss_total == read_miss_total + write_miss_total)
        else $error("miss count differs from read plus write misses");

endmodule

bind direct_mapped_write_back_cache dmwb_checker u_dmwb_checker (.*);

`default_nettype wire
